/* rtl/core/tal_pkg.sv */
package tal_pkg;

	// Averaging and sweep geometry.
	localparam int SAMPLES  = 8;
	localparam int CHANNELS = 16;

	// Field and datapath widths.
	localparam int ADC_W  = 12;
	localparam int CH_W   = 4;
	localparam int TEMP_W = 16;
	localparam int COEF_W = 32;
	localparam int SUM_W  = 20;
	localparam int CNT_W  = 8;
	localparam int IDX_W  = 8;
	localparam int X_W    = 16;
	// Numerator of the mean: sum * 16 plus half the divisor.
	localparam int NUM_W  = SUM_W + 5;
	localparam int REM_W  = 8;
	// Horner accumulator and the shift-add product register.
	localparam int ACC_W  = 35;
	localparam int P_W    = ACC_W + X_W + 1;
	localparam int T_W    = ACC_W - 8;
	localparam int STEP_W = 5;

	localparam logic [REM_W:0]   SAMPLES_V  = (REM_W + 1)'(SAMPLES);
	localparam logic [NUM_W-1:0] SAMPLES_HF = NUM_W'(SAMPLES / 2);
	localparam logic [CH_W-1:0]  LAST_CH    = CH_W'(CHANNELS - 1);

	// Coefficient register indexes.
	localparam logic [IDX_W-1:0] REG_CUBIC  = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_SQUARE = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_LINEAR = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_OFFSET = IDX_W'(3);

	// Coefficient reset values, signed Q15.16.
	localparam logic signed [COEF_W-1:0] CUBIC_RST  = -32'sd17572692;
	localparam logic signed [COEF_W-1:0] SQUARE_RST = 32'sd26268533;
	localparam logic signed [COEF_W-1:0] LINEAR_RST = -32'sd22989026;
	localparam logic signed [COEF_W-1:0] OFFSET_RST = 32'sd10406196;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL,
		ST_OUT
	} state_t;

endpackage

/* rtl/core/thermistor_average_and_linearize.sv */
// Thermistor averaging and cubic linearization.
// Input channel: adc_sample with in_valid/in_stall; one transfer per reading,
// SAMPLES readings per thermistor, thermistors in turn from 0 to CHANNELS-1.
// Output channel: channel, temperature (signed Q8.8), clipped and sweep_done
// with out_valid/out_stall; one result per group of SAMPLES readings.
// Configuration: cfg_index/cfg_data with cfg_valid/cfg_ready write the four
// Q15.16 coefficients; cfg_ready is always high, unknown indexes are ignored.
// Write coefficients only while no group is being evaluated.
// A reading that does not close a group is added to the sum without a stall. The
// closing reading starts a bit-serial restoring divide over the NUM_W = 25
// numerator bits for the mean and three Horner steps on a shift-add multiplier,
// one bit of x per cycle, then the result is loaded into the output register.
// in_stall stays high during that evaluation and while the result waits for
// the output register.
// When the receiver stalls, the output register holds its result and a new
// group can still be collected behind it.
// Reset restores the default coefficients and starts at channel 0 with an
// empty sum; no memory needs clearing.
module thermistor_average_and_linearize
	import tal_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [ADC_W-1:0]         adc_sample,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [CH_W-1:0]          channel,
	output logic signed [TEMP_W-1:0] temperature,
	output logic                     clipped,
	output logic                     sweep_done,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [IDX_W-1:0]         cfg_index,
	input  logic [COEF_W-1:0]        cfg_data
);

	state_t state_q, state_d;

	logic signed [COEF_W-1:0] coef_cubic_q, coef_square_q, coef_linear_q, coef_offset_q;
	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  count_q;
	logic [CH_W-1:0]   chan_q;
	logic [STEP_W-1:0] cyc_q;
	logic [1:0]        term_q;
	logic [NUM_W-1:0]  num_q;
	logic [NUM_W-1:0]  quo_q;
	logic [REM_W-1:0]  rem_q;
	logic [X_W-1:0]    xs_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [P_W-1:0]   p_q;
	logic out_valid_q;

	logic in_xfer, out_free, group_end, load_out;
	logic [SUM_W-1:0]  sum_nxt;
	logic [CNT_W:0]    count_inc;
	logic [REM_W:0]    trial;
	logic              quo_bit;
	logic [REM_W:0]    rem_nxt;
	logic [NUM_W-1:0]  quo_nxt;
	logic [X_W-1:0]    x_clamped;
	logic signed [P_W-1:0]    p_add, p_sum, p_nxt;
	logic signed [COEF_W-1:0] coef_sel;
	logic signed [ACC_W-1:0]  acc_step;
	logic signed [ACC_W-1:0]  acc_rnd;
	logic signed [T_W-1:0]    t_full;
	logic signed [TEMP_W-1:0] t_sat;
	logic                     t_clip;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign in_xfer   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	// Running sum and reading count of the current thermistor.
	assign sum_nxt   = sum_q + SUM_W'(adc_sample);
	assign count_inc = {1'b0, count_q} + (CNT_W + 1)'(1);
	assign group_end = !(count_inc < SAMPLES_V);

	// One restoring divide step per cycle, numerator entering MSB first.
	assign trial     = {rem_q, num_q[NUM_W-1]};
	assign quo_bit   = (trial >= SAMPLES_V);
	assign rem_nxt   = quo_bit ? (trial - SAMPLES_V) : trial;
	assign quo_nxt   = {quo_q[NUM_W-2:0], quo_bit};
	assign x_clamped = (quo_nxt[NUM_W-1:X_W] != '0) ? '1 : quo_nxt[X_W-1:0];

	// Shift-add multiply, one bit of x per cycle with an arithmetic right shift.
	// Starting from the rounding constant gives the rounded product after 16 steps.
	assign p_add = xs_q[0] ? {{(P_W-ACC_W){acc_q[ACC_W-1]}}, acc_q} : '0;
	assign p_sum = p_q + p_add;
	assign p_nxt = p_sum >>> 1;

	always_comb begin
		case (term_q)
			2'd0:    coef_sel = coef_square_q;
			2'd1:    coef_sel = coef_linear_q;
			default: coef_sel = coef_offset_q;
		endcase
	end

	assign acc_step = p_nxt[ACC_W-1:0] + {{(ACC_W-COEF_W){coef_sel[COEF_W-1]}}, coef_sel};

	// Q15.16 to Q8.8 with rounding, then saturation.
	assign acc_rnd = acc_q + ACC_W'(128);
	assign t_full  = acc_rnd[ACC_W-1:8];

	always_comb begin
		if (t_full > T_W'(32767)) begin
			t_sat  = 16'sh7fff;
			t_clip = 1'b1;
		end else if (t_full < -T_W'(32768)) begin
			t_sat  = 16'sh8000;
			t_clip = 1'b1;
		end else begin
			t_sat  = t_full[TEMP_W-1:0];
			t_clip = 1'b0;
		end
	end

	// Sequencer: next state.
	always_comb begin
		state_d  = state_q;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer && group_end) state_d = ST_DIV;
			end
			ST_DIV: begin
				if (cyc_q == STEP_W'(NUM_W - 1)) state_d = ST_MUL;
			end
			ST_MUL: begin
				if (cyc_q == STEP_W'(X_W - 1) && term_q == 2'd2) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Coefficient registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_cubic_q  <= CUBIC_RST;
			coef_square_q <= SQUARE_RST;
			coef_linear_q <= LINEAR_RST;
			coef_offset_q <= OFFSET_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CUBIC:  coef_cubic_q  <= cfg_data;
				REG_SQUARE: coef_square_q <= cfg_data;
				REG_LINEAR: coef_linear_q <= cfg_data;
				REG_OFFSET: coef_offset_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Accumulation state, step counter and channel index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
			chan_q  <= '0;
			cyc_q   <= '0;
			term_q  <= '0;
		end else begin
			if (in_xfer) begin
				if (group_end) begin
					sum_q   <= '0;
					count_q <= '0;
				end else begin
					sum_q   <= sum_nxt;
					count_q <= count_inc[CNT_W-1:0];
				end
			end
			if (load_out) begin
				chan_q <= (chan_q == LAST_CH) ? '0 : chan_q + CH_W'(1);
			end
			unique case (state_q)
				ST_DIV: begin
					cyc_q  <= (cyc_q == STEP_W'(NUM_W - 1)) ? '0 : cyc_q + STEP_W'(1);
					term_q <= '0;
				end
				ST_MUL: begin
					if (cyc_q == STEP_W'(X_W - 1)) begin
						cyc_q  <= '0;
						term_q <= term_q + 2'd1;
					end else begin
						cyc_q <= cyc_q + STEP_W'(1);
					end
				end
				default: begin
					cyc_q  <= '0;
					term_q <= '0;
				end
			endcase
		end
	end

	// Divider and multiplier datapath.
	always_ff @(posedge clk) begin
		if (in_xfer && group_end) begin
			num_q <= {1'b0, sum_nxt, 4'b0000} + SAMPLES_HF;
			quo_q <= '0;
			rem_q <= '0;
		end else if (state_q == ST_DIV) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			quo_q <= quo_nxt;
			rem_q <= rem_nxt[REM_W-1:0];
			if (cyc_q == STEP_W'(NUM_W - 1)) begin
				xs_q  <= x_clamped;
				acc_q <= {{(ACC_W-COEF_W){coef_cubic_q[COEF_W-1]}}, coef_cubic_q};
				p_q   <= P_W'(32768);
			end
		end else if (state_q == ST_MUL) begin
			xs_q <= {xs_q[0], xs_q[X_W-1:1]};
			if (cyc_q == STEP_W'(X_W - 1)) begin
				acc_q <= acc_step;
				p_q   <= P_W'(32768);
			end else begin
				p_q <= p_nxt;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			channel     <= chan_q;
			temperature <= t_sat;
			clipped     <= t_clip;
			sweep_done  <= (chan_q == LAST_CH);
		end
	end

endmodule

/* rtl/core/tal_checker.sv */
module tal_checker
	import tal_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic [CH_W-1:0]          channel,
	input logic signed [TEMP_W-1:0] temperature,
	input logic                     clipped,
	input logic                     sweep_done
);

	logic [CH_W-1:0] exp_chan_q;

	// Channel expected on the next result transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_chan_q <= '0;
		end else if (out_valid && !out_stall) begin
			exp_chan_q <= (channel == LAST_CH) ? '0 : channel + CH_W'(1);
		end
	end

	// A stalled result stays valid and holds its temperature and channel.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(temperature) && $stable(channel))
		else $error("stalled result changed");

	// Results walk the thermistors in order.
	a_chan_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> channel == exp_chan_q)
		else $error("result channel out of sequence");

	// The sweep mark sits on the last thermistor only.
	a_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sweep_done == (channel == LAST_CH))
		else $error("sweep_done does not match channel");

	// A saturated result carries one of the range limits.
	a_clip: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clipped |-> temperature == 16'sh7fff || temperature == 16'sh8000)
		else $error("clipped result is not at a limit");

endmodule

bind thermistor_average_and_linearize tal_checker u_tal_checker (.*);

/* tb/tb_thermistor_average_and_linearize.sv */
module tb_thermistor_average_and_linearize
	import tal_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	// One temperature reading as the block reports it.
	typedef struct packed {
		logic [CH_W-1:0]          ch;
		logic signed [TEMP_W-1:0] temp;
		logic                     clip;
		logic                     last;
	} reading_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [ADC_W-1:0]         adc_sample = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [CH_W-1:0]          channel;
	logic signed [TEMP_W-1:0] temperature;
	logic                     clipped;
	logic                     sweep_done;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [IDX_W-1:0]         cfg_index = '0;
	logic [COEF_W-1:0]        cfg_data = '0;

	// Readings waiting to be sent and temperatures waiting to come back.
	logic [ADC_W-1:0] pending_samples[$];
	reading_t         expected_readings[$];

	// Predicted block state: coefficients and the group being collected.
	logic signed [COEF_W-1:0] pred_cubic;
	logic signed [COEF_W-1:0] pred_square;
	logic signed [COEF_W-1:0] pred_linear;
	logic signed [COEF_W-1:0] pred_offset;
	logic [SUM_W-1:0]         grp_sum = '0;
	logic [CNT_W-1:0]         grp_count = '0;
	logic [CH_W-1:0]          cur_ch = '0;

	int errors = 0;
	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;

	thermistor_average_and_linearize u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.adc_sample  (adc_sample),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.channel     (channel),
		.temperature (temperature),
		.clipped     (clipped),
		.sweep_done  (sweep_done),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #5 clk = ~clk;

	// Mean of a group as Q0.16, then the cubic in Horner form, then Q8.8 with saturation.
	function automatic reading_t predict_reading(input logic [SUM_W-1:0] sum,
			input logic [CH_W-1:0] ch);
		longint   xv;
		longint   acc;
		longint   t;
		reading_t r;
		xv = (longint'(sum) * 16 + SAMPLES / 2) / SAMPLES;
		if (xv > 65535) begin
			xv = 65535;
		end
		acc = longint'(pred_cubic);
		acc = ((acc * xv + 32768) >>> 16) + longint'(pred_square);
		acc = ((acc * xv + 32768) >>> 16) + longint'(pred_linear);
		acc = ((acc * xv + 32768) >>> 16) + longint'(pred_offset);
		t = (acc + 128) >>> 8;
		r.clip = 1'b0;
		if (t > 32767) begin
			t = 32767;
			r.clip = 1'b1;
		end else if (t < -32768) begin
			t = -32768;
			r.clip = 1'b1;
		end
		r.temp = TEMP_W'(t);
		r.ch = ch;
		r.last = (ch == LAST_CH);
		return r;
	endfunction

	// Sender: presents queued readings and tracks the group on each transfer.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				grp_sum = grp_sum + SUM_W'(adc_sample);
				if (int'(grp_count) + 1 < SAMPLES) begin
					grp_count = grp_count + 1'b1;
				end else begin
					expected_readings.push_back(predict_reading(grp_sum, cur_ch));
					grp_sum = '0;
					grp_count = '0;
					cur_ch = (cur_ch == LAST_CH) ? '0 : cur_ch + 1'b1;
				end
			end
			if (!in_valid || !in_stall) begin
				if (pending_samples.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
					in_valid <= 1'b1;
					adc_sample <= pending_samples.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stalls and a field-by-field check of each transfer.
	always @(posedge clk) begin
		reading_t exp_r;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_readings.size() == 0) begin
					$display("%0t: unexpected reading ch=%0d temp=%0d clip=%0b last=%0b",
						$time, channel, temperature, clipped, sweep_done);
					errors++;
				end else begin
					exp_r = expected_readings.pop_front();
					if (channel !== exp_r.ch) begin
						$display("%0t: channel expected %0d actual %0d",
							$time, exp_r.ch, channel);
						errors++;
					end
					if (temperature !== exp_r.temp) begin
						$display("%0t: temperature expected %0d actual %0d",
							$time, exp_r.temp, temperature);
						errors++;
					end
					if (clipped !== exp_r.clip) begin
						$display("%0t: clipped expected %0b actual %0b",
							$time, exp_r.clip, clipped);
						errors++;
					end
					if (sweep_done !== exp_r.last) begin
						$display("%0t: sweep_done expected %0b actual %0b",
							$time, exp_r.last, sweep_done);
						errors++;
					end
				end
			end
			out_stall <= ($urandom_range(99) < rcv_idle_pct);
		end
	end

	// Writes one coefficient register and mirrors it into the prediction.
	task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_CUBIC:  pred_cubic = data;
			REG_SQUARE: pred_square = data;
			REG_LINEAR: pred_linear = data;
			REG_OFFSET: pred_offset = data;
			default: ;
		endcase
	endtask

	task automatic cfg_write_all(input logic [COEF_W-1:0] c3, input logic [COEF_W-1:0] c2,
			input logic [COEF_W-1:0] c1, input logic [COEF_W-1:0] c0);
		cfg_write(REG_CUBIC, c3);
		cfg_write(REG_SQUARE, c2);
		cfg_write(REG_LINEAR, c1);
		cfg_write(REG_OFFSET, c0);
	endtask

	// Random coefficient small enough that many results stay inside Q8.8.
	function automatic logic [COEF_W-1:0] mild_coef();
		return COEF_W'(longint'($urandom_range(33554432)) - 64'sd16777216);
	endfunction

	task automatic queue_const(input logic [ADC_W-1:0] val, input int n);
		repeat (n) pending_samples.push_back(val);
	endtask

	// Mostly uniform readings, with the rails now and then.
	task automatic queue_random(input int n);
		int pick;
		repeat (n) begin
			pick = $urandom_range(15);
			if (pick == 0) begin
				pending_samples.push_back('0);
			end else if (pick == 1) begin
				pending_samples.push_back('1);
			end else begin
				pending_samples.push_back(ADC_W'($urandom_range(4095)));
			end
		end
	endtask

	// Waits until every queued reading went out and every temperature came back,
	// then lets the evaluation latency pass.
	task automatic drain_results();
		do @(posedge clk);
		while (pending_samples.size() > 0 || in_valid || expected_readings.size() > 0);
		repeat (100) @(posedge clk);
	endtask

	initial begin
		pred_cubic = CUBIC_RST;
		pred_square = SQUARE_RST;
		pred_linear = LINEAR_RST;
		pred_offset = OFFSET_RST;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset coefficients: empty rail, full rail and a mixed group.
		queue_const('0, SAMPLES);
		queue_const('1, SAMPLES);
		pending_samples.push_back(12'h001);
		pending_samples.push_back(12'h800);
		pending_samples.push_back(12'h7FF);
		pending_samples.push_back(12'hFFE);
		pending_samples.push_back(12'h555);
		pending_samples.push_back(12'hAAA);
		pending_samples.push_back(12'h0F0);
		pending_samples.push_back(12'hF0F);
		drain_results();

		// Writes to indexes past the last register must leave everything alone.
		cfg_write(IDX_W'(REG_OFFSET + 1), '1);
		cfg_write({IDX_W{1'b1}}, 32'h8000_0000);
		queue_const('1, SAMPLES);
		drain_results();

		// Largest coefficients saturate high.
		cfg_write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		queue_const('0, SAMPLES);
		queue_const('1, SAMPLES);
		queue_random(SAMPLES);
		drain_results();

		// Most negative coefficients saturate low.
		cfg_write_all(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		queue_const('0, SAMPLES);
		queue_const('1, SAMPLES);
		queue_random(SAMPLES);
		drain_results();

		// All-zero polynomial.
		cfg_write_all('0, '0, '0, '0);
		queue_random(2 * SAMPLES);
		drain_results();

		// Sender rarely idles, receiver mostly stalls; reset coefficients.
		snd_idle_pct = 7;
		rcv_idle_pct = 71;
		cfg_write_all(CUBIC_RST, SQUARE_RST, LINEAR_RST, OFFSET_RST);
		queue_random(40 * SAMPLES);
		drain_results();

		// Sender mostly idles, receiver rarely stalls; random coefficients.
		snd_idle_pct = 71;
		rcv_idle_pct = 7;
		cfg_write_all(mild_coef(), mild_coef(), mild_coef(), mild_coef());
		queue_random(20 * SAMPLES);
		drain_results();
		cfg_write_all(mild_coef(), mild_coef(), mild_coef(), mild_coef());
		queue_random(20 * SAMPLES);
		drain_results();

		// No idling on either side.
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		cfg_write_all(CUBIC_RST, mild_coef(), LINEAR_RST, mild_coef());
		queue_random(27 * SAMPLES);
		drain_results();

		if (errors == 0) begin
			$display("tb_thermistor_average_and_linearize: PASS");
		end else begin
			$display("tb_thermistor_average_and_linearize: FAIL");
		end
		$finish;
	end

	// Hard stop well beyond the slowest correct run.
	initial begin
		#5ms;
		$display("tb_thermistor_average_and_linearize: FAIL");
		$finish;
	end

endmodule
